FILE: rtl/cyclic_shuffle_engine_core_assert.svh
// Assertion macros used by the checker of the cyclic shuffle engine.
`ifndef CYCLIC_SHUFFLE_ENGINE_CORE_ASSERT_SVH
`define CYCLIC_SHUFFLE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define CSE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define CSE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/cse_pkg.sv
// Package of the cyclic shuffle engine: widths, command codes and the microprogram.
`timescale 1ns / 1ps
`default_nettype none
package cse_pkg;

	localparam int MAX_ITEMS  = 1024;
	localparam int IDX_W      = $clog2(MAX_ITEMS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int WORD_W     = 32;
	localparam int DIV_CNT_W  = $clog2(WORD_W);
	localparam int CMD_W      = 2;
	localparam int UPC_W      = 4;
	localparam int OP_W       = 4;
	localparam int COND_W     = 3;

	typedef logic [UPC_W-1:0]  upc_t;
	typedef logic [OP_W-1:0]   op_t;
	typedef logic [COND_W-1:0] cond_t;
	typedef logic [CMD_W-1:0]  cmd_t;

	localparam cmd_t CMD_START = 2'd0;
	localparam cmd_t CMD_STEP  = 2'd1;
	localparam cmd_t CMD_READ  = 2'd2;

	// Datapath operations, one per control word.
	localparam op_t OP_NONE      = 4'd0;
	localparam op_t OP_CLR       = 4'd1;
	localparam op_t OP_ACCEPT    = 4'd2;
	localparam op_t OP_RST_IDX   = 4'd3;
	localparam op_t OP_FIN       = 4'd4;
	localparam op_t OP_DIV_START = 4'd5;
	localparam op_t OP_CALC_J    = 4'd6;
	localparam op_t OP_READ_IJ   = 4'd7;
	localparam op_t OP_WRITE_I   = 4'd8;
	localparam op_t OP_WRITE_J   = 4'd9;
	localparam op_t OP_READ_POS  = 4'd10;
	localparam op_t OP_LATCH_VAL = 4'd11;

	// Jump conditions.
	localparam cond_t C_NONE      = 3'd0;
	localparam cond_t C_ALWAYS    = 3'd1;
	localparam cond_t C_ACCEPT    = 3'd2;
	localparam cond_t C_DONE      = 3'd3;
	localparam cond_t C_DIV_DONE  = 3'd4;
	localparam cond_t C_ADDR_LAST = 3'd5;
	localparam cond_t C_OUT_FREE  = 3'd6;

	// Microprogram addresses.
	localparam upc_t UA_CLR   = 4'd0;
	localparam upc_t UA_IDLE  = 4'd1;
	localparam upc_t UA_START = 4'd2;
	localparam upc_t UA_SFIN  = 4'd3;
	localparam upc_t UA_CHK   = 4'd4;
	localparam upc_t UA_DIV   = 4'd5;
	localparam upc_t UA_J     = 4'd6;
	localparam upc_t UA_RDIJ  = 4'd7;
	localparam upc_t UA_WI    = 4'd8;
	localparam upc_t UA_WJ    = 4'd9;
	localparam upc_t UA_FIN   = 4'd10;
	localparam upc_t UA_RDP   = 4'd11;
	localparam upc_t UA_RDV   = 4'd12;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		upc_t  target;
		logic  hold;
	} ucode_t;

	typedef struct packed {
		logic accept;
		cmd_t cmd;
		logic done;
		logic div_done;
		logic addr_last;
		logic out_free;
	} seq_status_t;

	function automatic ucode_t mk_word(op_t op, cond_t cond, upc_t target, logic hold);
		ucode_t w;
		w.op     = op;
		w.cond   = cond;
		w.target = target;
		w.hold   = hold;
		return w;
	endfunction

	// When the condition holds the sequencer jumps to target; otherwise it
	// stays put if hold is set and falls through to the next word if not.
	function automatic ucode_t ucode_rom(upc_t addr);
		ucode_t w;
		case (addr)
			UA_CLR:   w = mk_word(OP_CLR,       C_ADDR_LAST, UA_IDLE, 1'b1);
			UA_IDLE:  w = mk_word(OP_ACCEPT,    C_ACCEPT,    UA_IDLE, 1'b1);
			UA_START: w = mk_word(OP_RST_IDX,   C_NONE,      UA_IDLE, 1'b0);
			UA_SFIN:  w = mk_word(OP_FIN,       C_OUT_FREE,  UA_CLR,  1'b1);
			UA_CHK:   w = mk_word(OP_DIV_START, C_DONE,      UA_FIN,  1'b0);
			UA_DIV:   w = mk_word(OP_NONE,      C_DIV_DONE,  UA_J,    1'b1);
			UA_J:     w = mk_word(OP_CALC_J,    C_NONE,      UA_IDLE, 1'b0);
			UA_RDIJ:  w = mk_word(OP_READ_IJ,   C_NONE,      UA_IDLE, 1'b0);
			UA_WI:    w = mk_word(OP_WRITE_I,   C_NONE,      UA_IDLE, 1'b0);
			UA_WJ:    w = mk_word(OP_WRITE_J,   C_NONE,      UA_IDLE, 1'b0);
			UA_FIN:   w = mk_word(OP_FIN,       C_OUT_FREE,  UA_IDLE, 1'b1);
			UA_RDP:   w = mk_word(OP_READ_POS,  C_NONE,      UA_IDLE, 1'b0);
			UA_RDV:   w = mk_word(OP_LATCH_VAL, C_ALWAYS,    UA_FIN,  1'b0);
			default:  w = mk_word(OP_NONE,      C_ALWAYS,    UA_IDLE, 1'b0);
		endcase
		return w;
	endfunction

	// Entry point of each command; the unused code goes straight to the result.
	function automatic upc_t dispatch(cmd_t cmd);
		upc_t a;
		case (cmd)
			CMD_START: a = UA_START;
			CMD_STEP:  a = UA_CHK;
			CMD_READ:  a = UA_RDP;
			default:   a = UA_FIN;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/cyclic_shuffle_engine_core.sv
// Top level of the cyclic shuffle engine: datapath, table, divider and sequencer.
// After reset the block sweeps the 1024-entry table to identity, one entry per
// cycle, and holds item_stall high throughout the sweep; configuration writes
// are taken at any time. A start command resets the step index, registers a
// result and then runs the same sweep before the next word is taken. A shuffle
// step accepts the word, launches the divider, waits on the bit-serial divider
// that forms the random word modulo the remaining count, forms j, swaps the
// table entries (it reads both entries together and writes them back one after
// the other) and registers the result; a step that finds the shuffle finished
// goes straight to the result. A read looks up the entry at the given position
// and registers it as the result. The next word can be accepted in the cycle
// after a result is registered, even while that result is still stalled.
`timescale 1ns / 1ps
`default_nettype none
module cyclic_shuffle_engine_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [cse_pkg::CNT_W-1:0]  item_count,
	input  wire logic                       item_valid,
	output logic                            item_stall,
	input  wire logic [cse_pkg::CMD_W-1:0]  cmd,
	input  wire logic [cse_pkg::WORD_W-1:0] random_word,
	input  wire logic [cse_pkg::IDX_W-1:0]  position,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output logic [cse_pkg::IDX_W-1:0]       chosen,
	output logic [cse_pkg::IDX_W-1:0]       entry_value,
	output logic                            done_res
);

	cse_pkg::ucode_t      ctrl;
	cse_pkg::seq_status_t status;

	logic [cse_pkg::CNT_W-1:0]  item_count_q;
	logic [cse_pkg::IDX_W-1:0]  i_q;
	logic [cse_pkg::IDX_W-1:0]  j_q;
	logic [cse_pkg::IDX_W-1:0]  addr_q;
	logic [cse_pkg::WORD_W-1:0] word_q;
	logic [cse_pkg::IDX_W-1:0]  pos_q;
	logic [cse_pkg::IDX_W-1:0]  chosen_q;
	logic [cse_pkg::IDX_W-1:0]  value_q;
	logic                       result_valid_q;
	logic [cse_pkg::IDX_W-1:0]  out_chosen_q;
	logic [cse_pkg::IDX_W-1:0]  out_value_q;
	logic                       out_done_q;

	logic                       accept;
	logic                       out_free;
	logic [cse_pkg::CNT_W-1:0]  eff_cnt;
	logic [cse_pkg::CNT_W-1:0]  remain;
	logic                       shuffle_done;
	logic [cse_pkg::CNT_W-1:0]  j_sum;

	logic                       tbl_we;
	logic [cse_pkg::IDX_W-1:0]  tbl_waddr;
	logic [cse_pkg::IDX_W-1:0]  tbl_wdata;
	logic                       tbl_re;
	logic [cse_pkg::IDX_W-1:0]  tbl_raddr_a;
	logic [cse_pkg::IDX_W-1:0]  tbl_rdata_a;
	logic [cse_pkg::IDX_W-1:0]  tbl_rdata_b;
	logic                       div_done;
	logic [cse_pkg::IDX_W-1:0]  div_rem;

	assign cfg_ready  = 1'b1;
	assign item_stall = (ctrl.op != cse_pkg::OP_ACCEPT);
	assign accept     = item_valid && !item_stall;
	assign out_free   = !result_valid_q || !result_stall;

	// Counts above the table size saturate; the shuffle is finished once the
	// step index reaches count - 1.
	always_comb begin
		if (item_count_q > cse_pkg::CNT_W'(cse_pkg::MAX_ITEMS)) begin
			eff_cnt = cse_pkg::CNT_W'(cse_pkg::MAX_ITEMS);
		end else begin
			eff_cnt = item_count_q;
		end
		shuffle_done = (eff_cnt <= cse_pkg::CNT_W'(1))
			|| ({1'b0, i_q} >= (eff_cnt - cse_pkg::CNT_W'(1)));
		remain = eff_cnt - cse_pkg::CNT_W'(1) - {1'b0, i_q};
		j_sum  = {1'b0, div_rem} + {1'b0, i_q} + cse_pkg::CNT_W'(1);
	end

	always_comb begin
		status.accept    = accept;
		status.cmd       = cmd;
		status.done      = shuffle_done;
		status.div_done  = div_done;
		status.addr_last = (addr_q == cse_pkg::IDX_W'(cse_pkg::MAX_ITEMS - 1));
		status.out_free  = out_free;
	end

	always_comb begin
		tbl_we      = 1'b0;
		tbl_waddr   = addr_q;
		tbl_wdata   = addr_q;
		tbl_re      = 1'b0;
		tbl_raddr_a = i_q;
		case (ctrl.op)
			cse_pkg::OP_CLR: begin
				tbl_we = 1'b1;
			end
			cse_pkg::OP_WRITE_I: begin
				tbl_we    = 1'b1;
				tbl_waddr = i_q;
				tbl_wdata = tbl_rdata_b;
			end
			cse_pkg::OP_WRITE_J: begin
				tbl_we    = 1'b1;
				tbl_waddr = j_q;
				tbl_wdata = tbl_rdata_a;
			end
			cse_pkg::OP_READ_IJ: begin
				tbl_re = 1'b1;
			end
			cse_pkg::OP_READ_POS: begin
				tbl_re      = 1'b1;
				tbl_raddr_a = pos_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			item_count_q <= item_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			addr_q <= '0;
		end else begin
			if (ctrl.op == cse_pkg::OP_CLR) begin
				addr_q <= addr_q + 1'b1;
			end
			if (ctrl.op == cse_pkg::OP_RST_IDX) begin
				i_q <= '0;
			end else if (ctrl.op == cse_pkg::OP_WRITE_J) begin
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q   <= random_word;
			pos_q    <= position;
			chosen_q <= '0;
			value_q  <= '0;
		end
		if (ctrl.op == cse_pkg::OP_CALC_J) begin
			j_q <= j_sum[cse_pkg::IDX_W-1:0];
		end
		if (ctrl.op == cse_pkg::OP_WRITE_J) begin
			chosen_q <= j_q;
		end
		if (ctrl.op == cse_pkg::OP_LATCH_VAL) begin
			value_q <= tbl_rdata_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctrl.op == cse_pkg::OP_FIN && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == cse_pkg::OP_FIN && out_free) begin
			out_chosen_q <= chosen_q;
			out_value_q  <= value_q;
			out_done_q   <= shuffle_done;
		end
	end

	assign result_valid = result_valid_q;
	assign chosen       = out_chosen_q;
	assign entry_value  = out_value_q;
	assign done_res     = out_done_q;

	cse_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	cse_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctrl.op == cse_pkg::OP_DIV_START),
		.dividend  (word_q),
		.divisor   (remain[cse_pkg::IDX_W-1:0]),
		.done      (div_done),
		.remainder (div_rem)
	);

	cse_table u_tbl (
		.clk     (clk),
		.we      (tbl_we),
		.waddr   (tbl_waddr),
		.wdata   (tbl_wdata),
		.re      (tbl_re),
		.raddr_a (tbl_raddr_a),
		.raddr_b (j_q),
		.rdata_a (tbl_rdata_a),
		.rdata_b (tbl_rdata_b)
	);

endmodule
`default_nettype wire

FILE: rtl/cse_divider.sv
// Bit-serial restoring divider that yields the remainder of a 32-bit word.
`timescale 1ns / 1ps
`default_nettype none
module cse_divider (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [cse_pkg::WORD_W-1:0] dividend,
	input  wire logic [cse_pkg::IDX_W-1:0]  divisor,
	output logic                            done,
	output logic [cse_pkg::IDX_W-1:0]       remainder
);

	logic [cse_pkg::WORD_W-1:0]    quo_q;
	logic [cse_pkg::IDX_W-1:0]     rem_q;
	logic [cse_pkg::IDX_W-1:0]     dvs_q;
	logic [cse_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [cse_pkg::IDX_W:0]       trial;
	logic [cse_pkg::IDX_W:0]       diff;
	logic [cse_pkg::IDX_W-1:0]     rem_next;

	// The partial remainder stays below the divisor, so one shifted-in bit
	// and a single compare and subtract keep it in range.
	always_comb begin
		trial = {rem_q, quo_q[cse_pkg::WORD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		if (trial >= {1'b0, dvs_q}) begin
			rem_next = diff[cse_pkg::IDX_W-1:0];
		end else begin
			rem_next = trial[cse_pkg::IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == cse_pkg::DIV_CNT_W'(cse_pkg::WORD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[cse_pkg::WORD_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

FILE: rtl/cse_table.sv
// Permutation table memory with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module cse_table (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [cse_pkg::IDX_W-1:0] waddr,
	input  wire logic [cse_pkg::IDX_W-1:0] wdata,
	input  wire logic                      re,
	input  wire logic [cse_pkg::IDX_W-1:0] raddr_a,
	input  wire logic [cse_pkg::IDX_W-1:0] raddr_b,
	output logic [cse_pkg::IDX_W-1:0]      rdata_a,
	output logic [cse_pkg::IDX_W-1:0]      rdata_b
);

	logic [cse_pkg::IDX_W-1:0] mem [cse_pkg::MAX_ITEMS];
	logic [cse_pkg::IDX_W-1:0] rdata_a_q;
	logic [cse_pkg::IDX_W-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a_q <= mem[raddr_a];
			rdata_b_q <= mem[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule
`default_nettype wire

FILE: rtl/cse_sequencer.sv
// Microprogram sequencer: step counter, control store lookup and jump logic.
`timescale 1ns / 1ps
`default_nettype none
module cse_sequencer (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cse_pkg::seq_status_t status,
	output cse_pkg::ucode_t           ctrl
);

	cse_pkg::upc_t   upc_q;
	cse_pkg::upc_t   upc_next;
	cse_pkg::upc_t   target;
	cse_pkg::ucode_t word;
	logic            taken;

	assign word = cse_pkg::ucode_rom(upc_q);

	always_comb begin
		case (word.cond)
			cse_pkg::C_NONE:      taken = 1'b0;
			cse_pkg::C_ALWAYS:    taken = 1'b1;
			cse_pkg::C_ACCEPT:    taken = status.accept;
			cse_pkg::C_DONE:      taken = status.done;
			cse_pkg::C_DIV_DONE:  taken = status.div_done;
			cse_pkg::C_ADDR_LAST: taken = status.addr_last;
			cse_pkg::C_OUT_FREE:  taken = status.out_free;
			default:              taken = 1'b0;
		endcase
		// An accepted word branches to the entry point of its command.
		if (word.cond == cse_pkg::C_ACCEPT) begin
			target = cse_pkg::dispatch(status.cmd);
		end else begin
			target = word.target;
		end
		if (taken) begin
			upc_next = target;
		end else if (word.hold) begin
			upc_next = upc_q;
		end else begin
			upc_next = upc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= cse_pkg::UA_CLR;
		end else begin
			upc_q <= upc_next;
		end
	end

	assign ctrl = word;

endmodule
`default_nettype wire

FILE: rtl/cse_checker.sv
// Port-level checker for the cyclic shuffle engine and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "cyclic_shuffle_engine_core_assert.svh"
module cse_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       item_valid,
	input wire logic                       item_stall,
	input wire logic                       result_valid,
	input wire logic                       result_stall,
	input wire logic [cse_pkg::IDX_W-1:0]  chosen,
	input wire logic [cse_pkg::IDX_W-1:0]  entry_value
);

	// A stalled result word must stay on the port.
	`CSE_ASSERT_NXT(a_result_held, result_valid && result_stall, result_valid,
		"result word dropped while stalled")

	// A word is worked on one at a time, so acceptance closes the input.
	`CSE_ASSERT_NXT(a_one_in_flight, item_valid && !item_stall, item_stall,
		"input accepted a second word right after the first")

	// A step never returns an entry and a read never names a partner.
	`CSE_ASSERT_IMP(a_fields_exclusive, result_valid, chosen == '0 || entry_value == '0,
		"both chosen and entry_value nonzero")

	// A new result comes only out of a word that was being worked on.
	`CSE_ASSERT_IMP(a_result_after_work, $rose(result_valid), $past(item_stall),
		"result appeared while the input was open")

endmodule

bind cyclic_shuffle_engine_core cse_checker u_cse_checker (.*);
`default_nettype wire
